// ===== hw/rtl/psd_pkg.sv =====
// Shared widths, codes and beat types for the period step and distance block.
package psd_pkg;

    localparam int YEAR_W    = 32;
    localparam int POS_W     = 16;
    localparam int STEP_W    = 32;
    localparam int DIST_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int DVD_W  = (STEP_W > YEAR_W) ? STEP_W : YEAR_W;
    localparam int REM_W  = CFG_W + 1;
    localparam int PROD_W = DVD_W + CFG_W;
    localparam int CMP_W  = (POS_W > CFG_W) ? POS_W : CFG_W;
    localparam int S1_W   = CMP_W + 2;
    localparam int WIDE_B = (PROD_W > YEAR_W) ? PROD_W : YEAR_W;
    localparam int WIDE_W = ((WIDE_B > S1_W) ? WIDE_B : S1_W) + 2;

    localparam logic [CFG_IDX_W-1:0] REG_PARTITIONS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_YEARS      = 1'b1;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_MEASURE = 1'b1;

    localparam logic [1:0] ORD_SAME    = 2'b00;
    localparam logic [1:0] ORD_LATER   = 2'b01;
    localparam logic [1:0] ORD_EARLIER = 2'b11;

    typedef struct packed {
        logic [CFG_W-1:0] n_raw;
        logic [CFG_W-1:0] n_eff;
        logic [CFG_W-1:0] m_eff;
    } psd_cfg_t;

    typedef struct packed {
        logic              op;
        logic              neg;
        logic              zero;
        logic              bad;
        logic [1:0]        ord;
        logic [YEAR_W-1:0] year;
        logic [POS_W-1:0]  pos;
        logic [POS_W:0]    pdiff;
    } psd_side_t;

    typedef struct packed {
        logic [YEAR_W-1:0] new_year;
        logic [POS_W-1:0]  new_position;
        logic [1:0]        order;
        logic [DIST_W-1:0] distance;
        logic              bad_input;
        logic              overflow;
    } psd_res_t;

endpackage

// ===== hw/rtl/psd_prep.sv =====
// Front stages: range checks, year and position differences, step magnitude, divider operand select.
module psd_prep
    import psd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic              op,
    input  logic [YEAR_W-1:0] year,
    input  logic [POS_W-1:0]  position,
    input  logic [STEP_W-1:0] steps,
    input  logic [YEAR_W-1:0] other_year,
    input  logic [POS_W-1:0]  other_position,
    input  psd_cfg_t          cfg,
    output logic              out_valid,
    output logic [DVD_W-1:0]  dividend,
    output logic [CFG_W-1:0]  divisor,
    output psd_side_t         side
);

    logic              v1_reg;
    logic              op1_reg;
    logic [YEAR_W-1:0] year1_reg;
    logic [POS_W-1:0]  pos1_reg;
    logic [STEP_W-1:0] mag1_reg;
    logic              neg1_reg;
    logic              zero1_reg;
    logic              bad1_reg;
    logic [YEAR_W:0]   ydiff1_reg;
    logic [POS_W:0]    pdiff1_reg;

    logic              v2_reg;
    logic [DVD_W-1:0]  dividend2_reg;
    logic [CFG_W-1:0]  divisor2_reg;
    psd_side_t         side2_reg;

    logic              neg1_next;
    logic [STEP_W-1:0] mag1_next;
    logic              pos_bad;
    logic              opos_bad;
    logic              bad1_next;
    logic [YEAR_W:0]   ydiff1_next;
    logic [POS_W:0]    pdiff1_next;

    logic [1:0]        ord2;
    logic [YEAR_W:0]   ydist2;
    logic [DVD_W-1:0]  dividend2_next;
    logic [CFG_W-1:0]  divisor2_next;
    psd_side_t         side2_next;

    always_comb begin
        neg1_next   = steps[STEP_W-1];
        mag1_next   = neg1_next ? (~steps + STEP_W'(1)) : steps;
        pos_bad     = (position == '0) || (CMP_W'(position) > CMP_W'(cfg.n_raw));
        opos_bad    = (other_position == '0) ||
                      (CMP_W'(other_position) > CMP_W'(cfg.n_raw));
        bad1_next   = pos_bad || ((op == OP_MEASURE) && opos_bad);
        ydiff1_next = {year[YEAR_W-1], year} - {other_year[YEAR_W-1], other_year};
        pdiff1_next = {1'b0, position} - {1'b0, other_position};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg    <= op;
            year1_reg  <= year;
            pos1_reg   <= position;
            mag1_reg   <= mag1_next;
            neg1_reg   <= neg1_next;
            zero1_reg  <= (steps == '0);
            bad1_reg   <= bad1_next;
            ydiff1_reg <= ydiff1_next;
            pdiff1_reg <= pdiff1_next;
        end
    end

    always_comb begin
        if (ydiff1_reg != '0) begin
            ord2 = ydiff1_reg[YEAR_W] ? ORD_EARLIER : ORD_LATER;
        end else if (pdiff1_reg != '0) begin
            ord2 = pdiff1_reg[POS_W] ? ORD_EARLIER : ORD_LATER;
        end else begin
            ord2 = ORD_SAME;
        end
        ydist2 = (ord2 == ORD_LATER) ? ydiff1_reg : (~ydiff1_reg + (YEAR_W+1)'(1));
        if (op1_reg == OP_MEASURE) begin
            dividend2_next = DVD_W'(ydist2[YEAR_W-1:0]);
            divisor2_next  = cfg.m_eff;
        end else begin
            dividend2_next = DVD_W'(mag1_reg);
            divisor2_next  = cfg.n_eff;
        end
        side2_next.op    = op1_reg;
        side2_next.neg   = neg1_reg;
        side2_next.zero  = zero1_reg;
        side2_next.bad   = bad1_reg;
        side2_next.ord   = (op1_reg == OP_MEASURE) ? ord2 : ORD_SAME;
        side2_next.year  = year1_reg;
        side2_next.pos   = pos1_reg;
        side2_next.pdiff = pdiff1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dividend2_reg <= dividend2_next;
            divisor2_reg  <= divisor2_next;
            side2_reg     <= side2_next;
        end
    end

    assign out_valid = v2_reg;
    assign dividend  = dividend2_reg;
    assign divisor   = divisor2_reg;
    assign side      = side2_reg;

endmodule

// ===== hw/rtl/psd_div.sv =====
// Restoring divider pipeline, one quotient bit per stage, side data alongside.
module psd_div
    import psd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    input  psd_side_t        side_in,
    output logic             out_valid,
    output logic [DVD_W-1:0] quot,
    output logic [CFG_W-1:0] rem,
    output psd_side_t        side_out
);

    logic             vld_reg  [DVD_W];
    logic [DVD_W-1:0] acc_reg  [DVD_W];
    logic [CFG_W-1:0] rem_reg  [DVD_W];
    logic [CFG_W-1:0] dsr_reg  [DVD_W];
    psd_side_t        side_reg [DVD_W];

    logic             vld_in   [DVD_W];
    logic [DVD_W-1:0] acc_in   [DVD_W];
    logic [CFG_W-1:0] rem_in   [DVD_W];
    logic [CFG_W-1:0] dsr_in   [DVD_W];
    psd_side_t        side_in_s [DVD_W];

    genvar i;
    generate
        for (i = 0; i < DVD_W; i++) begin : g_stage
            logic [REM_W-1:0] trial;
            logic             ge;
            logic [REM_W-1:0] diff;

            if (i == 0) begin : g_first
                assign vld_in[i]    = in_valid;
                assign acc_in[i]    = dividend;
                assign rem_in[i]    = '0;
                assign dsr_in[i]    = divisor;
                assign side_in_s[i] = side_in;
            end else begin : g_next
                assign vld_in[i]    = vld_reg[i-1];
                assign acc_in[i]    = acc_reg[i-1];
                assign rem_in[i]    = rem_reg[i-1];
                assign dsr_in[i]    = dsr_reg[i-1];
                assign side_in_s[i] = side_reg[i-1];
            end

            always_comb begin
                trial = {rem_in[i], acc_in[i][DVD_W-1]};
                diff  = trial - {1'b0, dsr_in[i]};
                ge    = (trial >= {1'b0, dsr_in[i]});
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= vld_in[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    acc_reg[i]  <= {acc_in[i][DVD_W-2:0], ge};
                    rem_reg[i]  <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
                    dsr_reg[i]  <= dsr_in[i];
                    side_reg[i] <= side_in_s[i];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DVD_W-1];
    assign quot      = acc_reg[DVD_W-1];
    assign rem       = rem_reg[DVD_W-1];
    assign side_out  = side_reg[DVD_W-1];

endmodule

// ===== hw/rtl/psd_post.sv =====
// Back stages: carry or borrow, span multiply, year or distance sum, result fields.
module psd_post
    import psd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DVD_W-1:0] quot,
    input  logic [CFG_W-1:0] rem,
    input  psd_side_t        side_in,
    input  psd_cfg_t         cfg,
    output logic             out_valid,
    output psd_res_t         res
);

    logic              va_reg;
    psd_side_t         sidea_reg;
    logic [DVD_W-1:0]  qa_reg;
    logic [S1_W-1:0]   s1a_reg;

    logic              vb_reg;
    psd_side_t         sideb_reg;
    logic [DVD_W-1:0]  qqb_reg;
    logic [S1_W-1:0]   npb_reg;

    logic              vc_reg;
    psd_side_t         sidec_reg;
    logic [PROD_W-1:0] prodc_reg;
    logic [S1_W-1:0]   npc_reg;

    logic              vd_reg;
    psd_side_t         sided_reg;
    logic [WIDE_W-1:0] wided_reg;
    logic [S1_W-1:0]   npd_reg;

    logic [S1_W-1:0]   pos_x;
    logic [S1_W-1:0]   rem_x;
    logic [S1_W-1:0]   n_x;
    logic [S1_W-1:0]   s1a_next;
    logic              carry;
    logic [S1_W-1:0]   npb_next;
    logic [DVD_W-1:0]  qqb_next;
    logic [CFG_W-1:0]  factor;
    logic [PROD_W-1:0] prodc_next;
    logic [WIDE_W-1:0] year_x;
    logic [WIDE_W-1:0] prod_x;
    logic [WIDE_W-1:0] pdiff_x;
    logic [WIDE_W-1:0] wided_next;
    logic [WIDE_W-YEAR_W:0] year_top;
    logic [WIDE_W-DIST_W:0] dist_top;
    logic              year_fits;
    logic              dist_fits;
    logic              np_fits;

    // stage A: position plus or minus remainder
    always_comb begin
        pos_x    = S1_W'(side_in.pos);
        rem_x    = S1_W'(rem);
        s1a_next = side_in.neg ? (pos_x - rem_x) : (pos_x + rem_x);
    end

    // stage B: carry or borrow into the span count
    always_comb begin
        n_x = S1_W'(cfg.n_eff);
        if ((sidea_reg.op != OP_ADVANCE) || sidea_reg.zero) begin
            carry = 1'b0;
        end else if (sidea_reg.neg) begin
            carry = s1a_reg[S1_W-1] || (s1a_reg == '0);
        end else begin
            carry = !s1a_reg[S1_W-1] && (s1a_reg > n_x);
        end
        if (carry) begin
            npb_next = sidea_reg.neg ? (s1a_reg + n_x) : (s1a_reg - n_x);
        end else begin
            npb_next = s1a_reg;
        end
        qqb_next = qa_reg + DVD_W'(carry);
    end

    // stage C: spans to years, or spans to positions
    always_comb begin
        factor     = (sideb_reg.op == OP_MEASURE) ? cfg.n_eff : cfg.m_eff;
        prodc_next = PROD_W'(qqb_reg) * PROD_W'(factor);
    end

    // stage D: final wide sum
    always_comb begin
        year_x  = {{(WIDE_W-YEAR_W){sidec_reg.year[YEAR_W-1]}}, sidec_reg.year};
        prod_x  = {{(WIDE_W-PROD_W){1'b0}}, prodc_reg};
        pdiff_x = {{(WIDE_W-POS_W-1){sidec_reg.pdiff[POS_W]}}, sidec_reg.pdiff};
        if (sidec_reg.op == OP_ADVANCE) begin
            wided_next = sidec_reg.neg ? (year_x - prod_x) : (year_x + prod_x);
        end else if (sidec_reg.ord == ORD_LATER) begin
            wided_next = prod_x + pdiff_x;
        end else begin
            wided_next = pdiff_x - prod_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sidea_reg <= side_in;
            qa_reg    <= quot;
            s1a_reg   <= s1a_next;
            sideb_reg <= sidea_reg;
            qqb_reg   <= qqb_next;
            npb_reg   <= npb_next;
            sidec_reg <= sideb_reg;
            prodc_reg <= prodc_next;
            npc_reg   <= npb_reg;
            sided_reg <= sidec_reg;
            wided_reg <= wided_next;
            npd_reg   <= npc_reg;
        end
    end

    always_comb begin
        year_top  = wided_reg[WIDE_W-1:YEAR_W-1];
        dist_top  = wided_reg[WIDE_W-1:DIST_W-1];
        year_fits = (&year_top) || (~|year_top);
        dist_fits = (&dist_top) || (~|dist_top);
        np_fits   = (npd_reg[S1_W-1:POS_W] == '0);
        res.bad_input = sided_reg.bad;
        if (sided_reg.op == OP_ADVANCE) begin
            res.new_year     = wided_reg[YEAR_W-1:0];
            res.new_position = npd_reg[POS_W-1:0];
            res.order        = ORD_SAME;
            res.distance     = '0;
            res.overflow     = !year_fits || !np_fits;
        end else begin
            res.new_year     = '0;
            res.new_position = '0;
            res.order        = sided_reg.ord;
            res.distance     = wided_reg[DIST_W-1:0];
            res.overflow     = !dist_fits;
        end
    end

    assign out_valid = vd_reg;

endmodule

// ===== hw/rtl/period_step_and_distance.sv =====
// Top level: config registers, front, divider and back pipelines, output skid.
//
//  channel  | handshake          | beat
//  s_       | s_valid / s_ready  | op, year, position, steps, other_year, other_position
//  m_       | m_valid / m_ready  | new_year, new_position, order, distance, flags
//  cfg_     | cfg_we             | cfg_addr, cfg_wdata
//
// One beat enters per cycle while s_ready is high; a result passes through
// two front stages, 32 divider stages (one quotient bit each), four back stages
// and the output register. The divider chain holds most of these stages.
// Reset clears the valid bits and loads N = 12, M = 1.
// A one-beat skid behind the output register holds a result under m_ready low;
// while it is full, s_ready is low and every stage holds.
module period_step_and_distance
    import psd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [YEAR_W-1:0]    s_year,
    input  logic [POS_W-1:0]     s_position,
    input  logic [STEP_W-1:0]    s_steps,
    input  logic [YEAR_W-1:0]    s_other_year,
    input  logic [POS_W-1:0]     s_other_position,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [YEAR_W-1:0]    m_new_year,
    output logic [POS_W-1:0]     m_new_position,
    output logic [1:0]           m_order,
    output logic [DIST_W-1:0]    m_distance,
    output logic                 m_bad_input,
    output logic                 m_overflow,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] n_reg;
    logic [CFG_W-1:0] m_reg;
    psd_cfg_t         cfg;

    logic             en;
    logic             prep_valid;
    logic [DVD_W-1:0] prep_dividend;
    logic [CFG_W-1:0] prep_divisor;
    psd_side_t        prep_side;
    logic             div_valid;
    logic [DVD_W-1:0] div_quot;
    logic [CFG_W-1:0] div_rem;
    psd_side_t        div_side;
    logic             post_valid;
    psd_res_t         post_res;

    logic             m_valid_reg;
    logic             m_valid_next;
    psd_res_t         out_reg;
    psd_res_t         out_next;
    psd_res_t         skid_reg;
    psd_res_t         skid_next;
    logic             skid_full_reg;
    logic             skid_full_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= CFG_W'(12);
            m_reg <= CFG_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PARTITIONS: n_reg <= cfg_wdata;
                REG_YEARS:      m_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        cfg.n_raw = n_reg;
        cfg.n_eff = (n_reg == '0) ? CFG_W'(1) : n_reg;
        cfg.m_eff = (m_reg == '0) ? CFG_W'(1) : m_reg;
    end

    assign en      = !skid_full_reg;
    assign s_ready = en;

    psd_prep u_prep (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (s_valid),
        .op             (s_op),
        .year           (s_year),
        .position       (s_position),
        .steps          (s_steps),
        .other_year     (s_other_year),
        .other_position (s_other_position),
        .cfg            (cfg),
        .out_valid      (prep_valid),
        .dividend       (prep_dividend),
        .divisor        (prep_divisor),
        .side           (prep_side)
    );

    psd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .dividend  (prep_dividend),
        .divisor   (prep_divisor),
        .side_in   (prep_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .rem       (div_rem),
        .side_out  (div_side)
    );

    psd_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_valid),
        .quot      (div_quot),
        .rem       (div_rem),
        .side_in   (div_side),
        .cfg       (cfg),
        .out_valid (post_valid),
        .res       (post_res)
    );

    always_comb begin
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        skid_next      = skid_reg;
        skid_full_next = skid_full_reg;
        if (skid_full_reg) begin
            if (m_ready) begin
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
        end else if (!m_valid_reg || m_ready) begin
            m_valid_next = post_valid;
            out_next     = post_res;
        end else if (post_valid) begin
            skid_next      = post_res;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_new_year     = out_reg.new_year;
    assign m_new_position = out_reg.new_position;
    assign m_order        = out_reg.order;
    assign m_distance     = out_reg.distance;
    assign m_bad_input    = out_reg.bad_input;
    assign m_overflow     = out_reg.overflow;

`ifndef SYNTHESIS
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(m_valid_reg && !m_ready && post_valid))
        else $error("skid filled without a stalled output and a new result");

    a_output_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("output beat dropped before it was taken");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for period_step_and_distance: directed table, random bursts, stalls.
`timescale 1ns / 1ps

module testbench;
    import psd_pkg::*;

    typedef struct packed {
        logic              op;
        logic [YEAR_W-1:0] year;
        logic [POS_W-1:0]  pos;
        logic [STEP_W-1:0] steps;
        logic [YEAR_W-1:0] oyear;
        logic [POS_W-1:0]  opos;
    } period_query_t;

    typedef struct packed {
        period_query_t q;
        logic          given;
        psd_res_t      want;
    } table_row_t;

    localparam longint YEAR_MAX = (longint'(1) << (YEAR_W - 1)) - 1;
    localparam longint YEAR_MIN = -YEAR_MAX - 1;
    localparam longint DIST_MAX = (longint'(1) << (DIST_W - 1)) - 1;
    localparam longint DIST_MIN = -DIST_MAX - 1;
    localparam longint POS_MAX  = (longint'(1) << POS_W) - 1;
    localparam int     STALL_LIMIT = 4000;
    localparam int     PRINT_CAP   = 100;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic                 s_op             = OP_ADVANCE;
    logic [YEAR_W-1:0]    s_year           = '0;
    logic [POS_W-1:0]     s_position       = '0;
    logic [STEP_W-1:0]    s_steps          = '0;
    logic [YEAR_W-1:0]    s_other_year     = '0;
    logic [POS_W-1:0]     s_other_position = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic [YEAR_W-1:0]    m_new_year;
    logic [POS_W-1:0]     m_new_position;
    logic [1:0]           m_order;
    logic [DIST_W-1:0]    m_distance;
    logic                 m_bad_input;
    logic                 m_overflow;
    logic                 cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr         = REG_PARTITIONS;
    logic [CFG_W-1:0]     cfg_wdata        = '0;

    logic [CFG_W-1:0] cfg_n = 16'd12;
    logic [CFG_W-1:0] cfg_m = 16'd1;

    psd_res_t   answers_owed [$];
    table_row_t directed [$];

    int mismatches   = 0;
    int beats        = 0;
    int measures     = 0;
    int bad_beats    = 0;
    int wrapped      = 0;
    int settings     = 1;
    int burst_left   = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    int regime       = 0;
    int regime_left  = 0;

    period_step_and_distance dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_year           (s_year),
        .s_position       (s_position),
        .s_steps          (s_steps),
        .s_other_year     (s_other_year),
        .s_other_position (s_other_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_new_year       (m_new_year),
        .m_new_position   (m_new_position),
        .m_order          (m_order),
        .m_distance       (m_distance),
        .m_bad_input      (m_bad_input),
        .m_overflow       (m_overflow),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic psd_res_t advance_or_measure(input period_query_t q,
                                                    input logic [CFG_W-1:0] n_raw,
                                                    input logic [CFG_W-1:0] m_raw);
        longint   yr, ps, st, oy, ops, n, m, mag, quo, rem, ny, np, dst;
        logic [1:0] ord;
        logic     bad, ovf;
        psd_res_t res;
        yr   = $signed(q.year);
        ps   = q.pos;
        st   = $signed(q.steps);
        oy   = $signed(q.oyear);
        ops  = q.opos;
        n    = (n_raw == 0) ? 64'sd1 : longint'(n_raw);
        m    = (m_raw == 0) ? 64'sd1 : longint'(m_raw);
        bad  = (ps < 1) || (ps > longint'(n_raw));
        ny   = 0;
        np   = 0;
        dst  = 0;
        ord  = ORD_SAME;
        if (q.op == OP_ADVANCE) begin
            ny = yr;
            np = ps;
            if (st != 0) begin
                mag = (st < 0) ? -st : st;
                quo = mag / n;
                rem = mag % n;
                if (st > 0) begin
                    if (ps + rem > n) begin
                        ny = yr + (quo + 1) * m;
                        np = ps + rem - n;
                    end else begin
                        ny = yr + quo * m;
                        np = ps + rem;
                    end
                end else begin
                    if (ps - rem <= 0) begin
                        ny = yr - (quo + 1) * m;
                        np = ps - rem + n;
                    end else begin
                        ny = yr - quo * m;
                        np = ps - rem;
                    end
                end
            end
            ovf = (ny < YEAR_MIN) || (ny > YEAR_MAX) || (np < 0) || (np > POS_MAX);
        end else begin
            bad = bad || (ops < 1) || (ops > longint'(n_raw));
            if (yr != oy)
                ord = (yr < oy) ? ORD_EARLIER : ORD_LATER;
            else if (ps != ops)
                ord = (ps < ops) ? ORD_EARLIER : ORD_LATER;
            if (ord == ORD_LATER)
                dst = n * ((yr - oy) / m - 1) + ps + (n - ops);
            else
                dst = -(n * ((oy - yr) / m - 1) + ops + (n - ps));
            ovf = (dst < DIST_MIN) || (dst > DIST_MAX);
        end
        res.new_year     = ny[YEAR_W-1:0];
        res.new_position = np[POS_W-1:0];
        res.order        = ord;
        res.distance     = dst[DIST_W-1:0];
        res.bad_input    = bad;
        res.overflow     = ovf;
        return res;
    endfunction

    function automatic table_row_t row(input logic op,
                                       input logic [YEAR_W-1:0] yr,
                                       input logic [POS_W-1:0] ps,
                                       input logic [STEP_W-1:0] st,
                                       input logic [YEAR_W-1:0] oy,
                                       input logic [POS_W-1:0] ops,
                                       input logic given = 1'b0,
                                       input logic [YEAR_W-1:0] ny = '0,
                                       input logic [POS_W-1:0] np = '0,
                                       input logic [1:0] ord = ORD_SAME,
                                       input logic [DIST_W-1:0] dst = '0,
                                       input logic bad = 1'b0,
                                       input logic ovf = 1'b0);
        table_row_t r;
        r.q.op                = op;
        r.q.year              = yr;
        r.q.pos               = ps;
        r.q.steps             = st;
        r.q.oyear             = oy;
        r.q.opos              = ops;
        r.given               = given;
        r.want.new_year       = ny;
        r.want.new_position   = np;
        r.want.order          = ord;
        r.want.distance       = dst;
        r.want.bad_input      = bad;
        r.want.overflow       = ovf;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return cfg_n + 1'b1;
            2: return POS_W'($urandom);
            3: return '1;
            default: return (cfg_n == 0) ? POS_W'($urandom) : POS_W'($urandom_range(1, cfg_n));
        endcase
    endfunction

    function automatic period_query_t random_query();
        period_query_t    q;
        int               span;
        int               k;
        logic [CFG_W-1:0] m_eff;
        m_eff = (cfg_m == 0) ? 16'd1 : cfg_m;
        span  = 3 * ((cfg_n == 0) ? 1 : int'(cfg_n));
        k     = $urandom_range(0, 8) - 4;
        q.op  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: q.year = $urandom;
            1: q.year = 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: q.year = 32'h8000_0000 + $urandom_range(0, 3);
            3: q.year = -$urandom_range(0, 500);
            default: q.year = 1900 + $urandom_range(0, 300);
        endcase
        q.pos = pick_position();
        case ($urandom_range(0, 7))
            0: q.steps = $urandom;
            1: q.steps = 32'h7FFF_FFFF;
            2: q.steps = 32'h8000_0000;
            3: q.steps = '0;
            default: q.steps = $urandom_range(0, 2 * span) - span;
        endcase
        case ($urandom_range(0, 5))
            0: q.oyear = $urandom;
            1: q.oyear = q.year;
            2: q.oyear = q.year + k * m_eff + $urandom_range(0, m_eff - 1);
            default: q.oyear = q.year + k * m_eff;
        endcase
        q.opos = pick_position();
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 64);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    task automatic send_query(input period_query_t q, input logic given, input psd_res_t want);
        psd_res_t res;
        s_valid          <= 1'b1;
        s_op             <= q.op;
        s_year           <= q.year;
        s_position       <= q.pos;
        s_steps          <= q.steps;
        s_other_year     <= q.oyear;
        s_other_position <= q.opos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = given ? want : advance_or_measure(q, cfg_n, cfg_m);
        answers_owed.push_back(res);
        beats++;
        if (q.op == OP_MEASURE) measures++;
        if (res.bad_input) bad_beats++;
        if (res.overflow) wrapped++;
    endtask

    task automatic write_span(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] m);
        // hold off until the pipe is empty
        s_valid <= 1'b0;
        while (answers_owed.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_PARTITIONS;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_addr  <= REG_YEARS;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_n  = n;
        cfg_m  = m;
        settings++;
    endtask

    always @(posedge aclk) begin
        if (regime_left == 0) begin
            regime      <= $urandom_range(0, 2);
            regime_left <= $urandom_range(64, 400);
        end else begin
            regime_left <= regime_left - 1;
        end
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ((regime == 1 && $urandom_range(0, 7) == 0) ||
                (regime == 2 && $urandom_range(0, 1) == 0))
                stall_left <= $urandom_range(1, 12);
        end
    end

    always @(posedge aclk) begin : result_check
        psd_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (answers_owed.size() == 0) begin
                report_mismatch("result with nothing owed", m_distance, '0);
            end else begin
                want = answers_owed.pop_front();
                if (m_new_year !== want.new_year)
                    report_mismatch("new_year", m_new_year, want.new_year);
                if (m_new_position !== want.new_position)
                    report_mismatch("new_position", m_new_position, want.new_position);
                if (m_order !== want.order)
                    report_mismatch("order", m_order, want.order);
                if (m_distance !== want.distance)
                    report_mismatch("distance", m_distance, want.distance);
                if (m_bad_input !== want.bad_input)
                    report_mismatch("bad_input", m_bad_input, want.bad_input);
                if (m_overflow !== want.overflow)
                    report_mismatch("overflow", m_overflow, want.overflow);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("testbench: no handshake for %0d cycles, %0d results owed",
                     STALL_LIMIT, answers_owed.size());
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        directed.push_back(row(OP_ADVANCE, 2020, 1, 0, 0, 0,
                               1'b1, 2020, 1, ORD_SAME, 0, 1'b0, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 12, 1, 0, 0,
                               1'b1, 2021, 1, ORD_SAME, 0, 1'b0, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 1, -1, 0, 0,
                               1'b1, 2019, 12, ORD_SAME, 0, 1'b0, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 4, 12, 0, 0,
                               1'b1, 2021, 4, ORD_SAME, 0, 1'b0, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 4, -12, 0, 0,
                               1'b1, 2019, 4, ORD_SAME, 0, 1'b0, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 5, 30, 0, 0));
        directed.push_back(row(OP_ADVANCE, 2020, 0, 0, 0, 0,
                               1'b1, 2020, 0, ORD_SAME, 0, 1'b1, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 16'hFFFF, 0, 0, 0,
                               1'b1, 2020, 16'hFFFF, ORD_SAME, 0, 1'b1, 1'b0));
        directed.push_back(row(OP_ADVANCE, 2020, 16'hFFFF, 1, 0, 0));
        directed.push_back(row(OP_ADVANCE, 2020, 0, -1, 0, 0));
        directed.push_back(row(OP_ADVANCE, 2020, 13, 7, 0, 0));
        directed.push_back(row(OP_ADVANCE, 32'h7FFF_FFFF, 12, 1, 0, 0,
                               1'b1, 32'h8000_0000, 1, ORD_SAME, 0, 1'b0, 1'b1));
        directed.push_back(row(OP_ADVANCE, 32'h8000_0000, 1, -1, 0, 0,
                               1'b1, 32'h7FFF_FFFF, 12, ORD_SAME, 0, 1'b0, 1'b1));
        directed.push_back(row(OP_ADVANCE, 0, 1, 32'h7FFF_FFFF, 0, 0));
        directed.push_back(row(OP_ADVANCE, 0, 1, 32'h8000_0000, 0, 0));
        directed.push_back(row(OP_MEASURE, 2020, 3, 0, 2020, 3,
                               1'b1, 0, 0, ORD_SAME, 0, 1'b0, 1'b0));
        directed.push_back(row(OP_MEASURE, 2021, 1, 0, 2020, 12,
                               1'b1, 0, 0, ORD_LATER, 1, 1'b0, 1'b0));
        directed.push_back(row(OP_MEASURE, 2020, 12, 0, 2021, 1,
                               1'b1, 0, 0, ORD_EARLIER, -1, 1'b0, 1'b0));
        directed.push_back(row(OP_MEASURE, 2020, 5, 0, 2020, 9,
                               1'b1, 0, 0, ORD_EARLIER, -4, 1'b0, 1'b0));
        directed.push_back(row(OP_MEASURE, 2020, 5, 0, 1990, 0));
        directed.push_back(row(OP_MEASURE, 2020, 1, 0, 2020, 16'hFFFF));
        directed.push_back(row(OP_MEASURE, 32'h7FFF_FFFF, 12, 0, 32'h8000_0000, 1));
        directed.push_back(row(OP_MEASURE, 32'h8000_0000, 1, 0, 32'h7FFF_FFFF, 12));
        directed.push_back(row(OP_MEASURE, 2024, 7, 0, 1788, 3));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            pace();
            send_query(directed[i].q, directed[i].given, directed[i].want);
        end

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: ;
                1: write_span(16'd1, 16'd1);
                2: write_span('1, '1);
                3: write_span(16'd0, 16'd0);
                4: write_span(16'd7, 16'd3);
                5: write_span('1, 16'd1);
                6: write_span(16'd1, '1);
                7: write_span(16'd12, 16'd4);
                8: write_span(CFG_W'($urandom_range(2, 60)), CFG_W'($urandom_range(2, 9)));
                default: write_span(CFG_W'($urandom), CFG_W'($urandom));
            endcase
            repeat (ph == 0 ? 130 : 112) begin
                pace();
                send_query(random_query(), 1'b0, '0);
            end
        end

        // drain, then allow the pipe to settle
        s_valid <= 1'b0;
        while (answers_owed.size() != 0) @(posedge aclk);
        repeat (48) @(posedge aclk);

        $display("testbench: %0d beats over %0d span settings, %0d advance and %0d measure",
                 beats, settings, beats - measures, measures);
        $display("testbench: %0d with a bad position, %0d wrapped, %0d field mismatches",
                 bad_beats, wrapped, mismatches);
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
